// ----- rtl/lkpr_pkg.sv -----
// lkpr_pkg: shared types, constants and functions for the keyed printable rotation cipher
// generator step (x * 75 mod 65537), key reduction mod 96 and printable-range rotation
// no dependencies
package lkpr_pkg;

    localparam int BYTE_W      = 8;
    localparam int GEN_W       = 17;
    localparam int KEY_W       = 7;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 17;

    typedef logic [BYTE_W-1:0]      byte_t;
    typedef logic [GEN_W-1:0]       gen_t;
    typedef logic [KEY_W-1:0]       key_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

    // register indexes
    localparam cfg_index_t REG_INITIAL_SEED = cfg_index_t'(0);
    localparam cfg_index_t REG_MODE         = cfg_index_t'(1);

    localparam int   LEHMER_MULT = 75;
    localparam int   LEHMER_MOD  = 65537;
    localparam int   PRINT_LO    = 32;
    localparam int   PRINT_SPAN  = 128 - 32;
    localparam gen_t SEED_RESET  = gen_t'(1);

    // one generator step: low 16 bits minus the rest, fold back if negative
    function automatic gen_t lehmer_step(input gen_t s);
        logic [22:0] prod;
        logic [17:0] diff;
        begin
            prod = 23'(s) * 23'(LEHMER_MULT);
            diff = {2'b00, prod[15:0]} - {11'b0, prod[22:16]};
            if (diff[17]) begin
                diff = diff + 18'(LEHMER_MOD);
            end
            return diff[GEN_W-1:0];
        end
    endfunction

    // x mod 96 = ((x >> 5) mod 3) * 32 + x[4:0]; mod 3 by summing base-4 digits
    function automatic key_t key_mod96(input gen_t x);
        logic [11:0] q;
        logic [4:0]  s1;
        logic [2:0]  s2;
        logic [1:0]  r;
        begin
            q  = x[16:5];
            s1 = 5'(q[1:0]) + 5'(q[3:2]) + 5'(q[5:4]) + 5'(q[7:6])
               + 5'(q[9:8]) + 5'(q[11:10]);
            s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
            if (s2 >= 3'd6) begin
                r = 2'(s2 - 3'd6);
            end else if (s2 >= 3'd3) begin
                r = 2'(s2 - 3'd3);
            end else begin
                r = s2[1:0];
            end
            return {r, x[4:0]};
        end
    endfunction

    function automatic byte_t rotate_byte(input byte_t b, input key_t key, input logic decrypt);
        logic [7:0] pos;
        logic [7:0] p;
        begin
            if (b < byte_t'(PRINT_LO) || b >= byte_t'(PRINT_LO + PRINT_SPAN)) begin
                return b;
            end
            pos = b - 8'(PRINT_LO);
            if (decrypt) begin
                p = pos - {1'b0, key};
                if (p[7]) begin
                    p = p + 8'(PRINT_SPAN);
                end
            end else begin
                p = pos + {1'b0, key};
                if (p >= 8'(PRINT_SPAN)) begin
                    p = p - 8'(PRINT_SPAN);
                end
            end
            return p + 8'(PRINT_LO);
        end
    endfunction

endpackage

// ----- rtl/lkpr_lehmer.sv -----
// lkpr_lehmer: generator state register, one step per byte, key output mod 96
// depends on lkpr_pkg
module lkpr_lehmer (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step_en,
    input  logic          restart,
    input  lkpr_pkg::gen_t seed,
    output lkpr_pkg::key_t key
);
    import lkpr_pkg::*;

    gen_t gen_reg;
    gen_t gen_next;

    always_comb begin
        gen_next = gen_reg;
        if (step_en) begin
            gen_next = lehmer_step(restart ? seed : gen_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg <= SEED_RESET;
        end else begin
            gen_reg <= gen_next;
        end
    end

    // key of the byte that sits in the rotate stage
    assign key = key_mod96(gen_reg);

endmodule

// ----- rtl/lcg_keyed_printable_rotation_cipher_core.sv -----
// Keyed printable rotation cipher core. Takes one byte per clock on the s_ stream unless
// m_tready back-pressure stalls it, and returns one byte per input on the m_ stream.
// Stages: input register, generator step (x*75 mod 65537, a recurrence in lkpr_lehmer
// that sets the rate), rotate into the output register. Bytes 32..127 are rotated within
// that range by the generator value mod 96, forward when mode is 0 and backward when
// mode is 1; other bytes pass unchanged but still step the generator. A beat with tuser
// set reloads initial_seed first. Writes of an illegal seed (0 or above 65536) are
// dropped. Configure only while the block is idle.
// depends on lkpr_pkg and lkpr_lehmer
module lcg_keyed_printable_rotation_cipher_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    // input stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  lkpr_pkg::byte_t         s_tdata,   // [7:0] byte_in
    input  logic                    s_tuser,   // [0] restart
    // result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output lkpr_pkg::byte_t         m_tdata,   // [7:0] byte_out
    // configuration writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  lkpr_pkg::cfg_index_t    cfg_index,
    input  lkpr_pkg::cfg_data_t     cfg_data
);
    import lkpr_pkg::*;

    gen_t  seed_reg;
    logic  mode_reg;

    logic  v1_reg;
    byte_t byte1_reg;
    logic  restart1_reg;
    logic  v2_reg;
    byte_t byte2_reg;
    logic  vout_reg;
    byte_t out_reg;

    logic  rdy1;
    logic  rdy2;
    logic  rdy_out;
    logic  adv12;
    key_t  key;
    logic  seed_ok;

    assign cfg_ready = 1'b1;
    // legal seed is 1..65536
    assign seed_ok = (cfg_data != '0) && !(cfg_data[16] && (cfg_data[15:0] != '0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= SEED_RESET;
            mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            if (cfg_index == REG_INITIAL_SEED && seed_ok) begin
                seed_reg <= cfg_data;
            end
            if (cfg_index == REG_MODE) begin
                mode_reg <= cfg_data[0];
            end
        end
    end

    // each stage takes a new beat when empty or when it hands its own on
    assign rdy_out  = !vout_reg || m_tready;
    assign rdy2     = !v2_reg || rdy_out;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign adv12    = v1_reg && rdy2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy_out) begin
                vout_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && rdy1) begin
            byte1_reg    <= s_tdata;
            restart1_reg <= s_tuser;
        end
        if (adv12) begin
            byte2_reg <= byte1_reg;
        end
        if (v2_reg && rdy_out) begin
            out_reg <= rotate_byte(byte2_reg, key, mode_reg);
        end
    end

    // generator steps as a beat enters the rotate stage, so its value pairs with byte2_reg
    lkpr_lehmer u_lehmer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (adv12),
        .restart (restart1_reg),
        .seed    (seed_reg),
        .key     (key)
    );

    assign m_tvalid = vout_reg;
    assign m_tdata  = out_reg;

endmodule

// ----- rtl/lkpr_core_checker.sv -----
// lkpr_core_checker: port-level assertions for the cipher core, bound to the top level
// depends on lkpr_pkg and lcg_keyed_printable_rotation_cipher_core
module lkpr_core_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  lkpr_pkg::byte_t      s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  lkpr_pkg::byte_t      m_tdata
);
    logic in_beat;

    assign in_beat = s_tvalid && s_tready;

    // a stalled result beat holds its data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // a waiting input beat is held by the source
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("input beat changed while waiting");

    // an empty output register or a free sink never blocks the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled with room in the pipe");

    // with the sink ready while it moves through the pipe, an accepted beat shows up at the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("result missing after input beat");

    // reset empties the output
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind lcg_keyed_printable_rotation_cipher_core lkpr_core_checker u_lkpr_core_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for lcg_keyed_printable_rotation_cipher_core
// streams bytes under several seed/mode settings and back-pressure mixes, checks every beat
// depends on lkpr_pkg and the core rtl
module tb_top;
    import lkpr_pkg::*;

    localparam int   CYCLE_LIMIT = 200000;
    localparam int   RAND_PHASES = 8;
    localparam int   PHASE_BYTES = 250;
    localparam gen_t SEED_TOP    = gen_t'(65536);

    typedef struct packed {
        byte_t data;
        logic  restart;
    } cipher_beat_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    byte_t      s_tdata   = '0;
    logic       s_tuser   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    byte_t      m_tdata;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = '0;
    cfg_data_t  cfg_data  = '0;

    cipher_beat_t pending_bytes[$];
    byte_t        expected_bytes[$];
    int           bytes_queued   = 0;
    int           bytes_returned = 0;
    int           error_count    = 0;
    int           cycle_count    = 0;
    int           idle_pct       = 0;
    int           stall_pct      = 0;
    bit           s_took         = 1'b0;

    // shadow copy of the core's registers and generator
    gen_t seed_shadow;
    logic mode_shadow;
    gen_t gen_shadow;

    lcg_keyed_printable_rotation_cipher_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // x * 75 mod 65537, done directly with a wide remainder
    function automatic gen_t lehmer_next(input gen_t g);
        int unsigned v;
        v = 32'(g);
        v = (v * LEHMER_MULT) % LEHMER_MOD;
        return gen_t'(v);
    endfunction

    function automatic byte_t cipher_byte(input byte_t b, input gen_t g, input logic decrypt);
        int unsigned key;
        int unsigned pos;
        if (b < PRINT_LO || b >= PRINT_LO + PRINT_SPAN) begin
            return b;
        end
        key = 32'(g);
        key = key % PRINT_SPAN;
        pos = b - PRINT_LO;
        if (decrypt) begin
            pos = (pos + PRINT_SPAN - key) % PRINT_SPAN;
        end else begin
            pos = (pos + key) % PRINT_SPAN;
        end
        return byte_t'(pos + PRINT_LO);
    endfunction

    task automatic queue_byte(input byte_t data, input logic restart);
        cipher_beat_t beat;
        beat.data    = data;
        beat.restart = restart;
        pending_bytes.push_back(beat);
        bytes_queued++;
    endtask

    // called at a falling edge; returns at a falling edge with cfg_valid still high
    task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (bytes_returned < bytes_queued) @(negedge aclk);
    endtask

    // input driver
    always @(negedge aclk) begin
        cipher_beat_t beat;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
                beat = pending_bytes.pop_front();
                s_tdata  <= beat.data;
                s_tuser  <= beat.restart;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // monitor and prediction on the rising edge
    always @(posedge aclk) begin
        byte_t want;
        s_took = s_tvalid && s_tready;
        if (!aresetn) begin
            seed_shadow = SEED_RESET;
            mode_shadow = 1'b0;
            gen_shadow  = SEED_RESET;
        end else begin
            if (m_tvalid && m_tready) begin
                bytes_returned++;
                if (expected_bytes.size() == 0) begin
                    error_count++;
                    $error("byte_out: expected no beat, got %0d", m_tdata);
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want) begin
                        error_count++;
                        $error("byte_out mismatch: expected %0d, got %0d", want, m_tdata);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_INITIAL_SEED) begin
                    // illegal seeds are dropped
                    if (cfg_data != '0 && cfg_data <= SEED_TOP) begin
                        seed_shadow = cfg_data;
                    end
                end else if (cfg_index == REG_MODE) begin
                    mode_shadow = cfg_data[0];
                end
            end
            if (s_took) begin
                if (s_tuser) begin
                    gen_shadow = seed_shadow;
                end
                if (gen_shadow == '0 || gen_shadow > SEED_TOP) begin
                    gen_shadow = SEED_RESET;
                end
                gen_shadow = lehmer_next(gen_shadow);
                expected_bytes.push_back(cipher_byte(s_tdata, gen_shadow, mode_shadow));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL lcg_keyed_printable_rotation_cipher_core");
            $finish;
        end
    end

    initial begin
        gen_t      top_seed;
        gen_t      seed;
        cfg_data_t bad_seed;
        logic      mode;
        top_seed = SEED_RESET;
        // seed whose first step lands on 65536, the fold-back corner
        for (int s = 1; s <= 65536; s++) begin
            if (lehmer_next(gen_t'(s)) == SEED_TOP) begin
                top_seed = gen_t'(s);
            end
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: seed 1, encrypt; range edges and high bytes
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h1F, 1'b0);
        queue_byte(8'h20, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h41, 1'b1);
        queue_byte(8'h7E, 1'b0);
        queue_byte(8'h20, 1'b0);
        queue_byte(8'hAA, 1'b0);
        wait_drained();

        // illegal seeds and unused indexes must leave things alone
        write_reg(REG_INITIAL_SEED, cfg_data_t'(0));
        write_reg(REG_INITIAL_SEED, cfg_data_t'(65537));
        write_reg(REG_INITIAL_SEED, cfg_data_t'(131071));
        write_reg(cfg_index_t'(2), cfg_data_t'(123));
        write_reg(cfg_index_t'(15), '1);
        write_reg(REG_MODE, '1);
        cfg_valid <= 1'b0;
        queue_byte(8'h55, 1'b1);
        queue_byte(8'h20, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h80, 1'b0);
        wait_drained();

        write_reg(REG_INITIAL_SEED, cfg_data_t'(SEED_TOP));
        write_reg(REG_INITIAL_SEED, cfg_data_t'(0));
        write_reg(REG_MODE, cfg_data_t'(17'h1FFFE));
        cfg_valid <= 1'b0;
        queue_byte(8'h7F, 1'b1);
        queue_byte(8'h20, 1'b0);
        queue_byte(8'hFF, 1'b0);
        wait_drained();

        write_reg(REG_INITIAL_SEED, cfg_data_t'(top_seed));
        write_reg(REG_MODE, cfg_data_t'(1));
        cfg_valid <= 1'b0;
        queue_byte(8'h20, 1'b1);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'h5A, 1'b0);

        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_drained();
            case (p % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 58;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 58;
                end
                default: begin
                    idle_pct  = 17;
                    stall_pct = 17;
                end
            endcase
            case ($urandom_range(3))
                0: seed = SEED_RESET;
                1: seed = SEED_TOP;
                default: seed = gen_t'($urandom_range(65536, 1));
            endcase
            write_reg(REG_INITIAL_SEED, cfg_data_t'(seed));
            if ($urandom_range(1)) begin
                bad_seed = $urandom_range(1) ? cfg_data_t'(0)
                                             : cfg_data_t'($urandom_range(131071, 65537));
                write_reg(REG_INITIAL_SEED, bad_seed);
            end
            // each back-pressure mix sees both directions
            mode = ((((p / 4) + p) % 2) != 0);
            write_reg(REG_MODE, {16'($urandom), mode});
            write_reg(cfg_index_t'($urandom_range(15, 2)), cfg_data_t'($urandom));
            cfg_valid <= 1'b0;
            for (int i = 0; i < PHASE_BYTES; i++) begin
                queue_byte($urandom_range(99) < 75 ? byte_t'($urandom_range(127, 32))
                                                   : byte_t'($urandom_range(255)),
                           (i == 0) || ($urandom_range(99) < 3));
            end
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (expected_bytes.size() != 0) begin
            error_count++;
            $error("byte_out: %0d beats never arrived", expected_bytes.size());
        end
        if (error_count == 0) begin
            $display("PASS lcg_keyed_printable_rotation_cipher_core");
        end else begin
            $display("FAIL lcg_keyed_printable_rotation_cipher_core");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/lkpr_pkg.sv
rtl/lkpr_lehmer.sv
rtl/lcg_keyed_printable_rotation_cipher_core.sv
rtl/lkpr_core_checker.sv
tb/tb_top.sv
